@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored while rst_n is low.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk and ignored while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ hw/rtl/swpg_pkg.sv @@
// Shared types, constants and helpers of the sliding window pair generator.
package swpg_pkg;

  localparam int WINDOW_DEPTH = 64;
  localparam int IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int ID_W         = 32;
  localparam int STAMP_W      = 48;
  localparam int LIMIT_CNT_W  = 6;
  localparam int LIMIT_TIME_W = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ID_W-1:0]    id_t;
  typedef logic [STAMP_W-1:0] stamp_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 2'd0,
    CFG_COUNT = 2'd1,
    CFG_TIME  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic                    mode_by_count;
    logic [LIMIT_CNT_W-1:0]  count_limit;
    logic [LIMIT_TIME_W-1:0] time_limit;
  } cfg_t;

  typedef struct packed {
    idx_t   rd_addr;
    logic   wr_en;
    idx_t   wr_addr;
    id_t    wr_id;
    stamp_t wr_stamp;
  } mem_req_t;

  typedef struct packed {
    logic valid;
    logic last;
    id_t  earlier;
    id_t  current;
  } emit_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIM,
    ST_EVICT,
    ST_APPEND,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // Ring slot at a given distance from the head.
  function automatic idx_t slot_of(input idx_t head, input idx_t off);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (IDX_W + 1)'(WINDOW_DEPTH)) begin
      sum = sum - (IDX_W + 1)'(WINDOW_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

@@ hw/rtl/swpg_if.sv @@
// Valid/ready channel interfaces for requests and emitted pairs.
interface swpg_in_if;
  import swpg_pkg::*;
  logic   valid;
  logic   ready;
  id_t    req_id;
  stamp_t stamp;

  modport source (output valid, output req_id, output stamp, input ready);
  modport sink   (input valid, input req_id, input stamp, output ready);
endinterface

interface swpg_out_if;
  import swpg_pkg::*;
  logic valid;
  logic ready;
  id_t  earlier_id;
  id_t  current_id;
  logic last_pair;

  modport source (output valid, output earlier_id, output current_id, output last_pair,
                  input ready);
  modport sink   (input valid, input earlier_id, input current_id, input last_pair,
                  output ready);
endinterface

@@ hw/rtl/sliding_window_pair_generator.sv @@
// Top level of the sliding window pair generator.
// Each request (req_id, stamp) first trims the window (count mode drops at most one
// oldest entry, time mode drops oldest entries whose stamp lies more than time_limit
// ticks away), is then appended, and then yields one pair per older entry with a
// different id, oldest first, the final pair flagged by last_pair. A request sees up
// to 63 older entries. The single read port of the window memory paces the work: one
// entry per cycle while scanning, unless the result channel stalls, and a read-compare
// pair per time check. The input is ready only between requests; the output register
// lets the last pair of one request wait while the next request is taken. No clearing
// pass runs after reset.
`include "assert_macros.svh"

module sliding_window_pair_generator (
  input  logic                              clk,
  input  logic                              rst_n,
  swpg_in_if.sink                           in_ch,
  swpg_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [swpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [swpg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import swpg_pkg::*;

  cfg_t     cfg_r;
  emit_t    emit;
  mem_req_t mem_req;
  id_t      rd_id;
  stamp_t   rd_stamp;
  logic     in_ready;
  logic     in_fire;
  logic     out_free;

  logic out_valid_r;
  id_t  out_earlier_r;
  id_t  out_current_r;
  logic out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_by_count <= 1'b1;
      cfg_r.count_limit   <= LIMIT_CNT_W'(8);
      cfg_r.time_limit    <= LIMIT_TIME_W'(100);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:  cfg_r.mode_by_count <= cfg_wdata[0];
        CFG_COUNT: cfg_r.count_limit   <= cfg_wdata[LIMIT_CNT_W-1:0];
        CFG_TIME:  cfg_r.time_limit    <= cfg_wdata[LIMIT_TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  swpg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_fire  (in_fire),
    .in_id    (in_ch.req_id),
    .in_stamp (in_ch.stamp),
    .in_ready (in_ready),
    .out_free (out_free),
    .emit     (emit),
    .mem_req  (mem_req),
    .rd_id    (rd_id),
    .rd_stamp (rd_stamp)
  );

  swpg_window_mem u_mem (
    .clk      (clk),
    .req      (mem_req),
    .rd_id    (rd_id),
    .rd_stamp (rd_stamp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_earlier_r <= emit.earlier;
      out_current_r <= emit.current;
      out_last_r    <= emit.last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.earlier_id = out_earlier_r;
  assign out_ch.current_id = out_current_r;
  assign out_ch.last_pair  = out_last_r;

  `ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ch.ready)
  `ASSERT_IMPLIES(a_emit_has_room, emit.valid, !out_valid_r || out_ch.ready)
  `ASSERT_NEXT(a_idle_after_last, emit.valid && emit.last, in_ch.ready)
endmodule

@@ hw/rtl/swpg_window_mem.sv @@
// Ring buffer storage for window ids and stamps with a registered read port.
module swpg_window_mem (
  input  logic                        clk,
  input  swpg_pkg::mem_req_t          req,
  output logic [swpg_pkg::ID_W-1:0]    rd_id,
  output logic [swpg_pkg::STAMP_W-1:0] rd_stamp
);
  import swpg_pkg::*;

  id_t    ids_mem    [WINDOW_DEPTH];
  stamp_t stamps_mem [WINDOW_DEPTH];
  id_t    rd_id_r;
  stamp_t rd_stamp_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      ids_mem[req.wr_addr]    <= req.wr_id;
      stamps_mem[req.wr_addr] <= req.wr_stamp;
    end
  end

  always_ff @(posedge clk) begin
    rd_id_r    <= ids_mem[req.rd_addr];
    rd_stamp_r <= stamps_mem[req.rd_addr];
  end

  assign rd_id    = rd_id_r;
  assign rd_stamp = rd_stamp_r;
endmodule

@@ hw/rtl/swpg_dist_cmp.sv @@
// Compare unit: absolute stamp distance against the time limit.
module swpg_dist_cmp (
  input  logic [swpg_pkg::STAMP_W-1:0]      stamp_a,
  input  logic [swpg_pkg::STAMP_W-1:0]      stamp_b,
  input  logic [swpg_pkg::LIMIT_TIME_W-1:0] limit,
  output logic                              too_far
);
  import swpg_pkg::*;

  stamp_t distance;

  always_comb begin
    if (stamp_a > stamp_b) begin
      distance = stamp_a - stamp_b;
    end else begin
      distance = stamp_b - stamp_a;
    end
    too_far = distance > STAMP_W'(limit);
  end
endmodule

@@ hw/rtl/swpg_ctrl.sv @@
// Sequencer that trims, appends to and scans the window for one request.
module swpg_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  swpg_pkg::cfg_t               cfg,
  input  logic                         in_fire,
  input  logic [swpg_pkg::ID_W-1:0]    in_id,
  input  logic [swpg_pkg::STAMP_W-1:0] in_stamp,
  output logic                         in_ready,
  input  logic                         out_free,
  output swpg_pkg::emit_t              emit,
  output swpg_pkg::mem_req_t           mem_req,
  input  logic [swpg_pkg::ID_W-1:0]    rd_id,
  input  logic [swpg_pkg::STAMP_W-1:0] rd_stamp
);
  import swpg_pkg::*;

  state_t state_r, state_nxt;
  idx_t   head_r, head_nxt;
  cnt_t   count_r, count_nxt;
  id_t    cur_id_r, cur_id_nxt;
  stamp_t cur_stamp_r, cur_stamp_nxt;
  cnt_t   rd_i_r, rd_i_nxt;
  idx_t   chk_i_r, chk_i_nxt;
  logic   chk_v_r, chk_v_nxt;
  logic   pend_v_r, pend_v_nxt;
  id_t    pend_id_r, pend_id_nxt;

  logic too_far;
  logic count_drop;
  logic full;
  logic chk_done;
  logic advance;
  logic issue;

  swpg_dist_cmp u_dist (
    .stamp_a (rd_stamp),
    .stamp_b (cur_stamp_r),
    .limit   (cfg.time_limit),
    .too_far (too_far)
  );

  always_comb begin
    count_drop = (count_r != '0) && (count_r > CNT_W'(cfg.count_limit));
    full       = count_r >= CNT_W'(WINDOW_DEPTH);
    // The entry held in the read register is consumed once it can go somewhere.
    chk_done   = chk_v_r && ((rd_id == cur_id_r) || !pend_v_r || out_free);
    advance    = !chk_v_r || chk_done;
    issue      = (rd_i_r + 1'b1) < count_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_TRIM;
      end
      ST_TRIM: begin
        if (cfg.mode_by_count || (count_r == '0)) begin
          state_nxt = ST_APPEND;
        end else begin
          state_nxt = ST_EVICT;
        end
      end
      ST_EVICT: begin
        state_nxt = too_far ? ST_TRIM : ST_APPEND;
      end
      ST_APPEND: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (advance && !issue) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!pend_v_r || out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    head_nxt         = head_r;
    count_nxt        = count_r;
    cur_id_nxt       = cur_id_r;
    cur_stamp_nxt    = cur_stamp_r;
    rd_i_nxt         = rd_i_r;
    chk_i_nxt        = chk_i_r;
    chk_v_nxt        = chk_v_r;
    pend_v_nxt       = pend_v_r;
    pend_id_nxt      = pend_id_r;
    emit             = '0;
    emit.current     = cur_id_r;
    emit.earlier     = pend_id_r;
    mem_req          = '0;
    mem_req.rd_addr  = head_r;
    mem_req.wr_id    = cur_id_r;
    mem_req.wr_stamp = cur_stamp_r;
    mem_req.wr_addr  = slot_of(head_r, count_r[IDX_W-1:0]);
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cur_id_nxt    = in_id;
          cur_stamp_nxt = in_stamp;
        end
      end
      ST_TRIM: begin
        if (cfg.mode_by_count && count_drop) begin
          head_nxt  = slot_of(head_r, IDX_W'(1));
          count_nxt = count_r - 1'b1;
        end
      end
      ST_EVICT: begin
        if (too_far) begin
          head_nxt  = slot_of(head_r, IDX_W'(1));
          count_nxt = count_r - 1'b1;
        end
      end
      ST_APPEND: begin
        mem_req.wr_en = 1'b1;
        if (full) begin
          // The oldest slot is overwritten and the head moves past it.
          mem_req.wr_addr = head_r;
          head_nxt        = slot_of(head_r, IDX_W'(1));
        end else begin
          count_nxt = count_r + 1'b1;
        end
        rd_i_nxt   = '0;
        chk_v_nxt  = 1'b0;
        pend_v_nxt = 1'b0;
      end
      ST_SCAN: begin
        if (chk_done && (rd_id != cur_id_r)) begin
          emit.valid  = pend_v_r;
          pend_id_nxt = rd_id;
          pend_v_nxt  = 1'b1;
        end
        if (advance) begin
          mem_req.rd_addr = slot_of(head_r, rd_i_r[IDX_W-1:0]);
          chk_i_nxt       = rd_i_r[IDX_W-1:0];
          chk_v_nxt       = issue;
          if (issue) rd_i_nxt = rd_i_r + 1'b1;
        end else begin
          // Re-read the held entry so the read register keeps it.
          mem_req.rd_addr = slot_of(head_r, chk_i_r);
        end
      end
      ST_FLUSH: begin
        if (pend_v_r && out_free) begin
          emit.valid = 1'b1;
          emit.last  = 1'b1;
          pend_v_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      chk_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      chk_v_r  <= chk_v_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_id_r    <= cur_id_nxt;
    cur_stamp_r <= cur_stamp_nxt;
    rd_i_r      <= rd_i_nxt;
    chk_i_r     <= chk_i_nxt;
    pend_id_r   <= pend_id_nxt;
  end
endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the sliding window pair generator.
`timescale 1ns / 100ps

module tb_top;
  import swpg_pkg::*;

  localparam int SETTLE_CYCLES = 300;
  // The slowest run is about 170 requests, each with up to 63 pairs and with receiver stalls.
  localparam int CYCLE_LIMIT   = 1_000_000;

  typedef struct {
    id_t  earlier;
    id_t  current;
    logic last;
  } pair_t;

  // Mirrors the window and register state and holds the pairs still owed by the block.
  class pair_scoreboard;
    id_t                     ring_id [WINDOW_DEPTH];
    stamp_t                  ring_stamp [WINDOW_DEPTH];
    int unsigned             head;
    int unsigned             fill;
    bit                      by_count;
    logic [LIMIT_CNT_W-1:0]  count_lim;
    logic [LIMIT_TIME_W-1:0] time_lim;
    pair_t                   due_pairs [$];
    int                      errors;

    function new();
      head      = 0;
      fill      = 0;
      by_count  = 1'b1;
      count_lim = LIMIT_CNT_W'(8);
      time_lim  = LIMIT_TIME_W'(100);
      errors    = 0;
    endfunction

    function int pending();
      return due_pairs.size();
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_MODE: begin
          by_count = value[0];
        end
        CFG_COUNT: begin
          count_lim = value[LIMIT_CNT_W-1:0];
        end
        CFG_TIME: begin
          time_lim = value[LIMIT_TIME_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void drop_oldest();
      if (fill != 0) begin
        head = (head + 1) % WINDOW_DEPTH;
        fill--;
      end
    endfunction

    function void note_request(id_t id, stamp_t stamp);
      stamp_t      distance;
      stamp_t      oldest;
      int unsigned slot;
      int unsigned i;
      int unsigned n_pairs;
      pair_t       p;
      if (by_count) begin
        if (fill > count_lim) begin
          drop_oldest();
        end
      end else begin
        while (fill != 0) begin
          oldest = ring_stamp[head];
          distance = (oldest > stamp) ? oldest - stamp : stamp - oldest;
          if (distance > stamp_t'(time_lim)) begin
            drop_oldest();
          end else begin
            break;
          end
        end
      end
      if (fill >= WINDOW_DEPTH) begin
        drop_oldest();
      end
      slot = (head + fill) % WINDOW_DEPTH;
      ring_id[slot]    = id;
      ring_stamp[slot] = stamp;
      fill++;
      n_pairs = 0;
      for (i = 0; i < fill - 1 && n_pairs < WINDOW_DEPTH - 1; i++) begin
        slot = (head + i) % WINDOW_DEPTH;
        if (ring_id[slot] != id) begin
          p.earlier = ring_id[slot];
          p.current = id;
          p.last    = 1'b0;
          due_pairs.insert(due_pairs.size(), p);
          n_pairs++;
        end
      end
      if (n_pairs != 0) begin
        due_pairs[due_pairs.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_pair(id_t earlier, id_t current, logic last);
      pair_t want;
      if (due_pairs.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected pair: earlier %h current %h last %b", earlier, current, last);
        end
        return;
      end
      want = due_pairs[0];
      due_pairs.delete(0);
      if (want.earlier !== earlier || want.current !== current || want.last !== last) begin
        errors++;
        if (errors <= 10) begin
          $display("pair mismatch: expected earlier %h current %h last %b, got %h %h %b",
                   want.earlier, want.current, want.last, earlier, current, last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic [15:0] stall_pat = 16'hFFFF;
  logic [5:0]  stall_step = '0;
  int          cycle_count = 0;

  pair_scoreboard sb = new();

  swpg_in_if  in_ch ();
  swpg_out_if out_ch ();

  sliding_window_pair_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // A new 16-bit stall pattern is picked each time stall_step wraps; a quarter of them never stall.
  always @(negedge clk) begin
    stall_step <= stall_step + 1'b1;
    if (stall_step == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        stall_pat <= 16'hFFFF;
      end else begin
        stall_pat <= 16'($urandom) | 16'h0001;
      end
    end
    out_ch.ready <= stall_pat[stall_step[3:0]];
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_pair(out_ch.earlier_id, out_ch.current_id, out_ch.last_pair);
    end
  end

  // Leaves valid high on return; the caller lowers it when the burst ends.
  task automatic send_request(input id_t id, input stamp_t stamp);
    in_ch.valid  <= 1'b1;
    in_ch.req_id <= id;
    in_ch.stamp  <= stamp;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(id, stamp);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
    @(negedge clk);
  endtask

  // A request with no pairs may still be in flight, so wait out a full request after draining.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_phase(input bit by_count, input logic [LIMIT_CNT_W-1:0] cnt_lim,
                              input logic [LIMIT_TIME_W-1:0] tm_lim, input int n_items);
    id_t         pool [4];
    id_t         id;
    stamp_t      cur;
    stamp_t      delta;
    logic [31:0] span;
    bit          jumps;
    int          burst_left;
    int          gap;
    int          i;
    wait_drained();
    write_reg(CFG_MODE, CFG_DATA_W'(by_count));
    write_reg(CFG_COUNT, CFG_DATA_W'(cnt_lim));
    write_reg(CFG_TIME, CFG_DATA_W'(tm_lim));
    foreach (pool[k]) begin
      if ($urandom_range(0, 3) == 0) begin
        pool[k] = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      end else begin
        pool[k] = $urandom;
      end
    end
    cur = stamp_t'({$urandom, $urandom});
    // Far jumps would keep a wide-open window from ever filling up.
    jumps = (tm_lim != 32'hFFFF_FFFF);
    span = (tm_lim > 1000) ? 32'd100 : tm_lim / 2 + 1;
    burst_left = $urandom_range(1, 8);
    for (i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        id = pool[$urandom_range(0, 3)];
      end else begin
        id = $urandom;
      end
      if (by_count || (jumps && $urandom_range(0, 19) == 0)) begin
        cur = stamp_t'({$urandom, $urandom});
      end else begin
        delta = stamp_t'($urandom_range(0, 2 * span));
        if ($urandom_range(0, 9) < 3) begin
          cur = cur - delta;
        end else begin
          cur = cur + delta;
        end
      end
      send_request(id, cur);
      burst_left--;
      if (i == n_items / 2) begin
        // Hold off until the block has delivered everything owed so far.
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
      end else if (burst_left <= 0) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 6);
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.req_id = '0;
    in_ch.stamp  = '0;
    out_ch.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_MODE;
    cfg_wdata    = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty window first, then a repeated id that must produce nothing.
    send_request(32'h0000_0000, 48'h0000_0000_0000);
    send_request(32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    send_request(32'hFFFF_FFFF, 48'h0000_0000_0000);
    send_request(32'hFFFF_FFFF, 48'h8000_0000_0000);
    send_request(32'h1234_5678, 48'h0000_0001_0000);
    send_request(32'h0000_0000, 48'h0000_0000_0005);
    send_request(32'hDEAD_BEEF, 48'h0000_0000_0007);

    // A lowered count limit trims only one entry per request.
    wait_drained();
    write_reg(CFG_COUNT, 32'd0);
    send_request(32'h0000_0001, 48'h0000_0000_000A);
    send_request(32'h0000_0002, 48'h0000_0000_000B);

    // Zero time limit keeps only entries with the very same stamp.
    wait_drained();
    write_reg(CFG_MODE, 32'd0);
    write_reg(CFG_TIME, 32'd0);
    send_request(32'h0000_0003, 48'h0000_0000_000B);
    send_request(32'h0000_0003, 48'h0000_0000_000B);
    send_request(32'h0000_0004, 48'h0000_0000_000B);
    send_request(32'h0000_0005, 48'h0000_0000_000C);

    // Widest time limit: distances right at the limit, past it, and running backward.
    wait_drained();
    write_reg(CFG_TIME, 32'hFFFF_FFFF);
    send_request(32'h0000_0006, 48'hFFFF_FFFF_FFFF);
    send_request(32'h0000_0007, 48'hFFFF_0000_0000);
    send_request(32'h0000_0008, 48'hFFFE_FFFF_FFFF);
    send_request(32'h0000_0009, 48'hFFFF_0000_0005);

    random_phase(1'b1, 6'd63, $urandom, 40);
    random_phase(1'b1, 6'($urandom_range(1, 62)), $urandom, 20);
    // Long enough that the window fills and the oldest entry gets evicted.
    random_phase(1'b0, 6'($urandom_range(0, 63)), 32'hFFFF_FFFF, 70);
    random_phase(1'b0, 6'($urandom_range(0, 63)), 32'($urandom_range(1, 200)), 20);
    random_phase(1'b0, 6'($urandom_range(0, 63)), 32'd0, 10);
    random_phase(1'b1, 6'd0, $urandom, 10);

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sliding_window_pair_generator.f @@
+incdir+hw/rtl
hw/rtl/swpg_pkg.sv
hw/rtl/swpg_if.sv
hw/rtl/swpg_window_mem.sv
hw/rtl/swpg_dist_cmp.sv
hw/rtl/swpg_ctrl.sv
hw/rtl/sliding_window_pair_generator.sv
tb/tb_top.sv
